FILE: rtl/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants for the thermal derating supervisor
// Register map, reset values, limit bounds, request payloads and the
// integral derating step.
// ----------------------------------------------------------------------------
`default_nettype none

package tds_pkg;

  localparam int unsigned DutyW = 17;
  localparam int unsigned VoltW = 15;
  localparam int unsigned CntW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [DutyW-1:0] DutyMax = 17'd100000;
  localparam logic [VoltW-1:0] VoltMax = 15'd24000;

  localparam logic [CntW-1:0] ThrLo = 4'd1;
  localparam logic [CntW-1:0] ThrHi = 4'd14;

  // Reset values of the configuration registers
  localparam logic signed [7:0] RstReleaseTemp  = 8'sd47;
  localparam logic signed [7:0] RstThrottleTemp = 8'sd49;
  localparam logic signed [7:0] RstShutdownTemp = 8'sd68;
  localparam logic signed [7:0] RstBoostTemp    = 8'sd63;
  localparam logic [CntW-1:0]   RstFaultTicks   = 4'd10;
  localparam logic [DutyW-1:0]  RstMinDuty      = 17'd40000;
  localparam logic [VoltW-1:0]  RstMinVoltage   = 15'd16000;

  // Limit movement per degree of error
  localparam logic signed [13:0] StepPerDeg  = 14'sd10;
  localparam logic signed [13:0] BoostPerDeg = 14'sd25;
  localparam logic signed [8:0]  NegErrClamp = -9'sd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RELEASE_TEMP  = 3'd0,
    REG_THROTTLE_TEMP = 3'd1,
    REG_SHUTDOWN_TEMP = 3'd2,
    REG_BOOST_TEMP    = 3'd3,
    REG_FAULT_TICKS   = 3'd4,
    REG_MIN_DUTY      = 3'd5,
    REG_MIN_VOLTAGE   = 3'd6
  } tds_reg_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_OVERHEAT = 2'd1,
    CAUSE_SENSOR   = 2'd2
  } tds_cause_e;

  typedef struct packed {
    logic signed [7:0] release_temp;
    logic signed [7:0] throttle_temp;
    logic signed [7:0] shutdown_temp;
    logic signed [7:0] boost_temp;
    logic [CntW-1:0]   fault_ticks;
    logic [DutyW-1:0]  min_duty;
    logic [VoltW-1:0]  min_voltage;
  } tds_cfg_t;

  typedef struct packed {
    logic signed [7:0] temperature;
    logic              sensor_valid;
    logic              sample_ready;
    logic              system_off;
    logic              pwm_mode;
    logic              display_idle;
  } tds_in_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_limit;
    logic [VoltW-1:0] voltage_limit;
    logic             limits_changed;
    logic             force_off;
    logic [1:0]       off_cause;
    logic             thermal_ok;
    logic             stepdown_warning;
  } tds_out_t;

  // One integral step: subtract the scaled error, clamp to hi, then to lo.
  function automatic logic [DutyW-1:0] tds_derate(
    input logic [DutyW-1:0] store,
    input logic signed [7:0] temp,
    input logic signed [7:0] thr_temp,
    input logic signed [7:0] boost_temp,
    input logic [DutyW-1:0] lo,
    input logic [DutyW-1:0] hi
  );
    logic signed [8:0]  err;
    logic signed [13:0] step;
    logic signed [18:0] acc;
    logic signed [18:0] lo_s;
    logic signed [18:0] hi_s;
    err  = $signed({temp[7], temp}) - $signed({thr_temp[7], thr_temp});
    lo_s = $signed({2'b00, lo});
    hi_s = $signed({2'b00, hi});
    if ((temp > boost_temp) && (err > 9'sd0)) begin
      step = 14'(err) * BoostPerDeg;
    end else begin
      if (err < NegErrClamp) begin
        err = NegErrClamp;
      end
      step = 14'(err) * StepPerDeg;
    end
    acc = $signed({2'b00, store}) - 19'(step);
    if (acc > hi_s) begin
      acc = hi_s;
    end
    if (acc < lo_s) begin
      acc = lo_s;
    end
    return acc[DutyW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tds_if.sv
// ----------------------------------------------------------------------------
// tds_if: request channels of the thermal derating supervisor
// Tick channel and result channel, valid/ready with flat payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tds_tick_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] temperature;
  logic              sensor_valid;
  logic              sample_ready;
  logic              system_off;
  logic              pwm_mode;
  logic              display_idle;

  modport source (
    output valid, temperature, sensor_valid, sample_ready, system_off,
           pwm_mode, display_idle,
    input  ready
  );
  modport sink (
    input  valid, temperature, sensor_valid, sample_ready, system_off,
           pwm_mode, display_idle,
    output ready
  );
endinterface

interface tds_result_if;
  logic        valid;
  logic        ready;
  logic [16:0] duty_limit;
  logic [14:0] voltage_limit;
  logic        limits_changed;
  logic        force_off;
  logic [1:0]  off_cause;
  logic        thermal_ok;
  logic        stepdown_warning;

  modport source (
    output valid, duty_limit, voltage_limit, limits_changed, force_off,
           off_cause, thermal_ok, stepdown_warning,
    input  ready
  );
  modport sink (
    input  valid, duty_limit, voltage_limit, limits_changed, force_off,
           off_cause, thermal_ok, stepdown_warning,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/tds_cfg_regs.sv
// ----------------------------------------------------------------------------
// tds_cfg_regs: configuration register file
// Seven write-only registers loaded from the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module tds_cfg_regs
  import tds_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output tds_cfg_t                 cfg_o
);

  tds_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tds_reg_e'(cfg_idx_i))
        REG_RELEASE_TEMP:  cfg_d.release_temp  = $signed(cfg_wdata_i[7:0]);
        REG_THROTTLE_TEMP: cfg_d.throttle_temp = $signed(cfg_wdata_i[7:0]);
        REG_SHUTDOWN_TEMP: cfg_d.shutdown_temp = $signed(cfg_wdata_i[7:0]);
        REG_BOOST_TEMP:    cfg_d.boost_temp    = $signed(cfg_wdata_i[7:0]);
        REG_FAULT_TICKS:   cfg_d.fault_ticks   = cfg_wdata_i[CntW-1:0];
        REG_MIN_DUTY:      cfg_d.min_duty      = cfg_wdata_i[DutyW-1:0];
        REG_MIN_VOLTAGE:   cfg_d.min_voltage   = cfg_wdata_i[VoltW-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_temp  <= RstReleaseTemp;
      cfg_q.throttle_temp <= RstThrottleTemp;
      cfg_q.shutdown_temp <= RstShutdownTemp;
      cfg_q.boost_temp    <= RstBoostTemp;
      cfg_q.fault_ticks   <= RstFaultTicks;
      cfg_q.min_duty      <= RstMinDuty;
      cfg_q.min_voltage   <= RstMinVoltage;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/tds_step.sv
// ----------------------------------------------------------------------------
// tds_step: per-tick supervisor state and next-state logic
// Fault timer, overheat latch, throttle hysteresis and derating limits.
// The result reflects the state after this tick; state commits on en_i.
// ----------------------------------------------------------------------------
`default_nettype none

module tds_step
  import tds_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  tds_in_t   item_i,
  input  tds_cfg_t  cfg_i,
  output tds_out_t  res_o
);

  logic [CntW-1:0]  fault_cnt_q, fault_cnt_d;
  logic             overheat_q, overheat_d;
  logic             throttle_q, throttle_d;
  logic [DutyW-1:0] duty_q, duty_d;
  logic [VoltW-1:0] volt_q, volt_d;

  logic [CntW-1:0]  thr;
  logic [DutyW-1:0] nd;
  logic [VoltW-1:0] nv;
  logic             force_off;
  logic             changed;
  tds_cause_e       cause;

  always_comb begin
    // threshold saturates into 1..14
    thr = cfg_i.fault_ticks;
    if (thr < ThrLo) thr = ThrLo;
    if (thr > ThrHi) thr = ThrHi;

    fault_cnt_d = fault_cnt_q;
    overheat_d  = overheat_q;
    throttle_d  = throttle_q;
    duty_d      = duty_q;
    volt_d      = volt_q;
    nd          = duty_q;
    nv          = volt_q;
    force_off   = 1'b0;
    changed     = 1'b0;
    cause       = CAUSE_NONE;

    // sensor-fault timer; fires once, then parks at thr+1
    if (!item_i.sensor_valid) begin
      if (fault_cnt_q == thr) begin
        if (!item_i.system_off) begin
          force_off = 1'b1;
          cause     = CAUSE_SENSOR;
        end
        fault_cnt_d = thr + 4'd1;
      end else if (fault_cnt_q < thr) begin
        fault_cnt_d = fault_cnt_q + 4'd1;
      end
    end else begin
      fault_cnt_d = '0;
    end

    if (item_i.sensor_valid) begin
      if (item_i.temperature > cfg_i.shutdown_temp) begin
        overheat_d = 1'b1;
      end else if (overheat_q && (item_i.temperature < cfg_i.throttle_temp)) begin
        overheat_d = 1'b0;
      end
      if (overheat_d && !item_i.system_off) begin
        force_off = 1'b1;
        cause     = CAUSE_OVERHEAT;
      end

      if (item_i.sample_ready) begin
        if (item_i.temperature > cfg_i.throttle_temp) begin
          throttle_d = 1'b1;
        end else if (throttle_q && (item_i.temperature < cfg_i.release_temp)) begin
          throttle_d = 1'b0;
        end

        if (item_i.system_off || !throttle_d) begin
          nd = DutyMax;
          nv = VoltMax;
        end else if (item_i.pwm_mode) begin
          nd = tds_derate(duty_q, item_i.temperature, cfg_i.throttle_temp,
                          cfg_i.boost_temp, cfg_i.min_duty, DutyMax);
        end else begin
          nv = VoltW'(tds_derate(DutyW'(volt_q), item_i.temperature,
                                 cfg_i.throttle_temp, cfg_i.boost_temp,
                                 DutyW'(cfg_i.min_voltage), DutyW'(VoltMax)));
        end

        if ((nd != duty_q) || (nv != volt_q)) begin
          duty_d  = nd;
          volt_d  = nv;
          changed = 1'b1;
        end
      end
    end

    res_o.duty_limit       = duty_d;
    res_o.voltage_limit    = volt_d;
    res_o.limits_changed   = changed;
    res_o.force_off        = force_off;
    res_o.off_cause        = cause;
    res_o.thermal_ok       = !((fault_cnt_d >= thr) || overheat_d);
    res_o.stepdown_warning = item_i.display_idle && !item_i.system_off &&
                             item_i.sensor_valid && throttle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_cnt_q <= '0;
      overheat_q  <= 1'b0;
      throttle_q  <= 1'b0;
      duty_q      <= DutyMax;
      volt_q      <= VoltMax;
    end else if (en_i) begin
      fault_cnt_q <= fault_cnt_d;
      overheat_q  <= overheat_d;
      throttle_q  <= throttle_d;
      duty_q      <= duty_d;
      volt_q      <= volt_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/thermal_derating_supervisor.sv
// ----------------------------------------------------------------------------
// thermal_derating_supervisor: per-tick thermal protection and derating
// Top level: tick register, supervisor step logic, result register.
// ----------------------------------------------------------------------------
// One request per tick carries a temperature and status flags; one result
// comes back per tick with the duty and voltage limits, a change flag, a
// force-off request with its cause, and the thermal OK and step-down warning
// flags. Throughput is one tick per clock cycle unless the result side
// stalls: a tick is captured in the input register, all supervisor logic
// runs in the following cycle, and the result lands in the output register.
// The input register takes a new tick whenever it is empty or its contents
// move on, so a stalled sink blocks new ticks only once the input register
// also holds a tick. Supervisor state commits only when a tick moves into
// the result register, so every tick sees the state left by the one before
// it. The user must write configuration registers through the plain write
// port while no tick is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_derating_supervisor
  import tds_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  tds_tick_if.sink                 tick_i,
  tds_result_if.source             result_o
);

  tds_cfg_t cfg;
  tds_in_t  tick_q, tick_d;
  logic     tick_vld_q;
  tds_out_t res_q, res_d;
  logic     res_vld_q;
  logic     advance;   // tick register may move into the result register
  logic     step_en;   // a tick is actually processed this cycle

  // config registers
  tds_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance      = !res_vld_q || result_o.ready;
  assign step_en      = tick_vld_q && advance;
  assign tick_i.ready = !tick_vld_q || advance;

  always_comb begin
    tick_d.temperature  = tick_i.temperature;
    tick_d.sensor_valid = tick_i.sensor_valid;
    tick_d.sample_ready = tick_i.sample_ready;
    tick_d.system_off   = tick_i.system_off;
    tick_d.pwm_mode     = tick_i.pwm_mode;
    tick_d.display_idle = tick_i.display_idle;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
    end else if (tick_i.ready) begin
      tick_vld_q <= tick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.valid && tick_i.ready) begin
      tick_q <= tick_d;
    end
  end

  // supervisor state and next-state logic
  tds_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .item_i (tick_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= tick_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid            = res_vld_q;
  assign result_o.duty_limit       = res_q.duty_limit;
  assign result_o.voltage_limit    = res_q.voltage_limit;
  assign result_o.limits_changed   = res_q.limits_changed;
  assign result_o.force_off        = res_q.force_off;
  assign result_o.off_cause        = res_q.off_cause;
  assign result_o.thermal_ok       = res_q.thermal_ok;
  assign result_o.stepdown_warning = res_q.stepdown_warning;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a force-off request always carries a cause, and a cause only with force-off
  a_cause_matches_force : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_q.force_off == (res_q.off_cause != CAUSE_NONE))
  ) else $error("force_off and off_cause disagree");

  // a held tick is neither lost nor overwritten while the result side stalls
  a_tick_held : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (tick_vld_q && !advance) |=> (tick_vld_q && $stable(tick_q))
  ) else $error("held tick overwritten during stall");

  // a processed tick shows up as a valid result on the next cycle
  a_step_to_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step_en |=> res_vld_q
  ) else $error("processed tick did not produce a result");

endmodule

`default_nettype wire

FILE: tb/tds_checker.sv
// ----------------------------------------------------------------------------
// tds_checker: result checker for the thermal derating supervisor
// Tracks config writes and accepted tick requests, predicts the result of
// each tick and compares every accepted result request with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tds_checker
  import tds_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  tds_tick_if                 tick_i,
  tds_result_if               result_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  tds_cfg_t         cfg_q;
  logic [CntW-1:0]  fault_cnt_q;
  logic             overheat_q;
  logic             throttling_q;
  logic [DutyW-1:0] duty_q;
  logic [VoltW-1:0] volt_q;
  tds_out_t         supervisor_reports_q[$];
  int unsigned      miss_cnt = 0;

  // Integral step on one limit, then clamp to hi and after that to lo.
  function automatic int next_limit(input int store, input int temp,
                                    input int lo, input int hi);
    int err;
    int step;
    err = temp - int'($signed(cfg_q.throttle_temp));
    if (temp > int'($signed(cfg_q.boost_temp)) && err > 0) begin
      step = err * int'(BoostPerDeg);
    end else begin
      if (err < int'(NegErrClamp)) begin
        err = int'(NegErrClamp);
      end
      step = err * int'(StepPerDeg);
    end
    store -= step;
    if (store > hi) begin
      store = hi;
    end
    if (store < lo) begin
      store = lo;
    end
    return store;
  endfunction

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      miss_cnt++;
      if (miss_cnt <= 10) begin
        $display("%0t  %s mismatch: expected %0d, got %0d", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    int         thr;
    int         temp;
    int         nd;
    int         nv;
    logic       force_off;
    logic       changed;
    tds_cause_e cause;
    tds_out_t   want;
    if (!rst_ni) begin
      cfg_q = '{release_temp:  RstReleaseTemp,
                throttle_temp: RstThrottleTemp,
                shutdown_temp: RstShutdownTemp,
                boost_temp:    RstBoostTemp,
                fault_ticks:   RstFaultTicks,
                min_duty:      RstMinDuty,
                min_voltage:   RstMinVoltage};
      fault_cnt_q  = '0;
      overheat_q   = 1'b0;
      throttling_q = 1'b0;
      duty_q       = DutyMax;
      volt_q       = VoltMax;
      supervisor_reports_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (tds_reg_e'(cfg_idx_i))
          REG_RELEASE_TEMP:  cfg_q.release_temp  = cfg_wdata_i[7:0];
          REG_THROTTLE_TEMP: cfg_q.throttle_temp = cfg_wdata_i[7:0];
          REG_SHUTDOWN_TEMP: cfg_q.shutdown_temp = cfg_wdata_i[7:0];
          REG_BOOST_TEMP:    cfg_q.boost_temp    = cfg_wdata_i[7:0];
          REG_FAULT_TICKS:   cfg_q.fault_ticks   = cfg_wdata_i[CntW-1:0];
          REG_MIN_DUTY:      cfg_q.min_duty      = cfg_wdata_i[DutyW-1:0];
          REG_MIN_VOLTAGE:   cfg_q.min_voltage   = cfg_wdata_i[VoltW-1:0];
          default: ;
        endcase
      end

      if (tick_i.valid && tick_i.ready) begin
        temp      = int'($signed(tick_i.temperature));
        force_off = 1'b0;
        changed   = 1'b0;
        cause     = CAUSE_NONE;
        // out-of-range thresholds fold to 1 and 14
        thr = int'(cfg_q.fault_ticks);
        if (thr < int'(ThrLo)) begin
          thr = int'(ThrLo);
        end
        if (thr > int'(ThrHi)) begin
          thr = int'(ThrHi);
        end

        if (!tick_i.sensor_valid) begin
          // fire once at the threshold, then park one above it
          if (int'(fault_cnt_q) == thr) begin
            if (!tick_i.system_off) begin
              force_off = 1'b1;
              cause     = CAUSE_SENSOR;
            end
            fault_cnt_q = CntW'(thr + 1);
          end else if (int'(fault_cnt_q) < thr) begin
            fault_cnt_q++;
          end
        end else begin
          fault_cnt_q = '0;
          if (temp > int'($signed(cfg_q.shutdown_temp))) begin
            overheat_q = 1'b1;
          end else if (overheat_q && temp < int'($signed(cfg_q.throttle_temp))) begin
            overheat_q = 1'b0;
          end
          if (overheat_q && !tick_i.system_off) begin
            force_off = 1'b1;
            cause     = CAUSE_OVERHEAT;
          end

          if (tick_i.sample_ready) begin
            if (temp > int'($signed(cfg_q.throttle_temp))) begin
              throttling_q = 1'b1;
            end else if (throttling_q && temp < int'($signed(cfg_q.release_temp))) begin
              throttling_q = 1'b0;
            end
            nd = int'(duty_q);
            nv = int'(volt_q);
            if (tick_i.system_off || !throttling_q) begin
              nd = int'(DutyMax);
              nv = int'(VoltMax);
            end else if (tick_i.pwm_mode) begin
              nd = next_limit(nd, temp, int'(cfg_q.min_duty), int'(DutyMax));
            end else begin
              nv = next_limit(nv, temp, int'(cfg_q.min_voltage), int'(VoltMax));
            end
            if (nd != int'(duty_q) || nv != int'(volt_q)) begin
              duty_q  = DutyW'(nd);
              volt_q  = VoltW'(nv);
              changed = 1'b1;
            end
          end
        end

        want.duty_limit       = duty_q;
        want.voltage_limit    = volt_q;
        want.limits_changed   = changed;
        want.force_off        = force_off;
        want.off_cause        = cause;
        want.thermal_ok       = !((int'(fault_cnt_q) >= thr) || overheat_q);
        want.stepdown_warning = tick_i.display_idle && !tick_i.system_off &&
                                tick_i.sensor_valid && throttling_q;
        supervisor_reports_q.push_back(want);
      end

      if (result_i.valid && result_i.ready) begin
        if (supervisor_reports_q.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10) begin
            $display("%0t  result request with no tick outstanding", $time);
          end
        end else begin
          want = supervisor_reports_q.pop_front();
          report_field("duty_limit", want.duty_limit, result_i.duty_limit);
          report_field("voltage_limit", want.voltage_limit, result_i.voltage_limit);
          report_field("limits_changed", want.limits_changed, result_i.limits_changed);
          report_field("force_off", want.force_off, result_i.force_off);
          report_field("off_cause", want.off_cause, result_i.off_cause);
          report_field("thermal_ok", want.thermal_ok, result_i.thermal_ok);
          report_field("stepdown_warning", want.stepdown_warning,
                       result_i.stepdown_warning);
        end
      end
    end
    pending_o    <= supervisor_reports_q.size();
    mismatches_o <= miss_cnt;
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top of the thermal derating supervisor testbench
// Drives config writes and tick requests with random gaps, stalls the result
// side in random bursts, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
  import tds_pkg::*;

  // Covers sender gaps plus receiver stalls plus pipeline over ~1750 ticks
  // with a wide margin.
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned PhaseTicks  = 248;
  // Pipeline drain plus slack before touching config or ending the run.
  localparam int unsigned DrainCycles = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                sink_ready = 1'b0;
  int unsigned         mismatches;
  int unsigned         pending;
  int unsigned         gap_pct = 0;     // odds (%) of an idle burst before a tick
  int unsigned         stall_pct = 0;   // odds (%) per cycle of a result stall burst
  int unsigned         stall_left = 0;
  int                  center_temp = 0; // temperature the random walk hovers around
  int unsigned         cycle_count;

  tds_tick_if   tick_ch();
  tds_result_if result_ch();

  thermal_derating_supervisor i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .tick_i      (tick_ch),
    .result_o    (result_ch)
  );

  tds_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .tick_i       (tick_ch),
    .result_i     (result_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  // Result side back-pressure: ready drops in random bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      stall_left <= $urandom_range(17, 0);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  assign result_ch.ready = sink_ready;

  function automatic int clip8(input int v);
    return (v > 127) ? 127 : ((v < -128) ? -128 : v);
  endfunction

  // One tick request; an optional idle burst first, then hold valid until
  // the handshake. Valid stays high on return so back-to-back ticks never
  // see a low/high pair in one step.
  task automatic drive_tick(input int temp, input bit sensor_ok, input bit sample,
                            input bit off, input bit pwm, input bit idle);
    if ($urandom_range(99, 0) < gap_pct) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk_i);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.temperature  <= 8'(temp);
    tick_ch.sensor_valid <= sensor_ok;
    tick_ch.sample_ready <= sample;
    tick_ch.system_off   <= off;
    tick_ch.pwm_mode     <= pwm;
    tick_ch.display_idle <= idle;
    do @(posedge clk_i); while (!tick_ch.ready);
  endtask

  // Stop sending, wait for every predicted result, then let the pipe empty.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input tds_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Rewrite all registers while idle. Bits above a narrow register's width
  // carry random junk; the block must ignore them.
  task automatic load_config(input int rel, input int thr, input int shut, input int boost,
                             input int unsigned faults, input int unsigned min_d,
                             input int unsigned min_v);
    settle();
    write_reg(REG_RELEASE_TEMP,  {9'($urandom), 8'(rel)});
    write_reg(REG_THROTTLE_TEMP, {9'($urandom), 8'(thr)});
    write_reg(REG_SHUTDOWN_TEMP, {9'($urandom), 8'(shut)});
    write_reg(REG_BOOST_TEMP,    {9'($urandom), 8'(boost)});
    write_reg(REG_FAULT_TICKS,   {13'($urandom), 4'(faults)});
    write_reg(REG_MIN_DUTY,      17'(min_d));
    write_reg(REG_MIN_VOLTAGE,   {2'($urandom), 15'(min_v)});
    cfg_we <= 1'b0;
    center_temp = thr;
  endtask

  // Mostly a temperature random walk around the throttle point, with runs
  // of invalid sensor readings, sticky off/PWM flags, and a little noise.
  task automatic run_phase(input int unsigned n);
    int          walk;
    int unsigned bad_run;
    bit          off;
    bit          pwm;
    walk    = center_temp;
    bad_run = 0;
    off     = 1'b0;
    pwm     = 1'($urandom_range(1, 0));
    repeat (n) begin
      if ($urandom_range(99, 0) < 8) begin
        drive_tick(int'($urandom_range(255, 0)) - 128, 1'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        if (bad_run == 0 && $urandom_range(99, 0) < 3) begin
          bad_run = $urandom_range(16, 1);
        end
        if ($urandom_range(99, 0) < 2) begin
          off = !off;
        end
        if ($urandom_range(99, 0) < 2) begin
          pwm = !pwm;
        end
        if ($urandom_range(99, 0) < 5) begin
          walk = clip8(center_temp + int'($urandom_range(40, 0)) - 20);
        end else begin
          walk = clip8(walk + int'($urandom_range(8, 0)) - 4 + (center_temp - walk) / 16);
        end
        drive_tick(walk, bad_run == 0, $urandom_range(99, 0) < 85, off, pwm,
                   $urandom_range(99, 0) < 70);
        if (bad_run != 0) begin
          bad_run--;
        end
      end
    end
  endtask

  initial begin : stimulus
    int          thr;
    int unsigned min_d;
    int unsigned min_v;
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_RELEASE_TEMP;
    cfg_wdata            <= '0;
    tick_ch.valid        <= 1'b0;
    tick_ch.temperature  <= '0;
    tick_ch.sensor_valid <= 1'b0;
    tick_ch.sample_ready <= 1'b0;
    tick_ch.system_off   <= 1'b0;
    tick_ch.pwm_mode     <= 1'b0;
    tick_ch.display_idle <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 25;
    stall_pct <= 6;

    // Directed ticks on the reset register values.
    drive_tick(127, 1, 1, 0, 1, 1);   // overheat latch, throttle, boosted duty step
    drive_tick(-128, 1, 1, 0, 1, 1);  // latch and throttle both release
    drive_tick(55, 1, 1, 0, 0, 1);    // voltage derating, warning up
    drive_tick(48, 1, 1, 0, 0, 1);    // small negative error inside hysteresis
    drive_tick(64, 1, 1, 0, 0, 0);    // boosted voltage step, display busy
    drive_tick(63, 1, 0, 0, 0, 1);    // no sample: throttle and limits untouched
    drive_tick(70, 1, 1, 1, 1, 1);    // system off: latch sets, no force-off
    drive_tick(60, 1, 1, 0, 1, 1);    // still latched, system on: force-off
    drive_tick(30, 1, 1, 0, 1, 0);    // cool down releases everything
    // Invalid sensor long enough to fire once and park; off for a few ticks.
    for (int k = 0; k < 12; k++) begin
      drive_tick(127, 0, 1, k inside {[3:5]}, 1, 1);
    end
    drive_tick(50, 1, 1, 0, 1, 1);    // valid reading clears the fault count

    // Extremes: every threshold at the bottom, threshold 0, minimums above max.
    load_config(-128, -128, -128, -128, 0, 131071, 32767);
    run_phase(PhaseTicks);
    // Extremes: throttle/shutdown never reached, threshold 15, minimums zero.
    load_config(-128, 127, 127, 127, 15, 0, 0);
    run_phase(PhaseTicks);
    // Deep derating down to a zero floor, one-tick fault threshold, no idling.
    gap_pct = 0;
    stall_pct <= 0;
    load_config(20, 30, 100, 40, 1, 0, 0);
    run_phase(PhaseTicks);

    gap_pct = 25;
    stall_pct <= 6;
    for (int p = 0; p < 3; p++) begin
      thr   = int'($urandom_range(130, 0)) - 40;
      min_d = ($urandom_range(3, 0) == 0) ? $urandom_range(131071, 0)
                                          : $urandom_range(100000, 0);
      min_v = ($urandom_range(3, 0) == 0) ? $urandom_range(32767, 0)
                                          : $urandom_range(24000, 0);
      load_config(clip8(thr - int'($urandom_range(20, 0))), thr,
                  clip8(thr + int'($urandom_range(40, 0))),
                  clip8(thr + int'($urandom_range(30, 0))),
                  $urandom_range(15, 0), min_d, min_v);
      run_phase(PhaseTicks);
    end

    // Final stretch back on reset values with both sides running flat out.
    gap_pct = 0;
    stall_pct <= 0;
    load_config(RstReleaseTemp, RstThrottleTemp, RstShutdownTemp, RstBoostTemp,
                RstFaultTicks, RstMinDuty, RstMinVoltage);
    run_phase(PhaseTicks);

    settle();
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tds_pkg.sv
rtl/tds_if.sv
rtl/tds_cfg_regs.sv
rtl/tds_step.sv
rtl/thermal_derating_supervisor.sv
tb/tds_checker.sv
tb/testbench.sv
